// ===== src/xrng_pkg.sv =====
// ----------------------------------------------------------------------------
// xrng_pkg
// Shared types and constants for the xorshift64* range/unit generator.
// ----------------------------------------------------------------------------
`default_nettype none

package xrng_pkg;

	localparam logic [63:0] GEN_MULT    = 64'd2685821657736338717;
	localparam logic [63:0] GEN_DEFAULT = 64'h9E3779B97F4A7C15;

	localparam int VALUE_W = 53;
	localparam int BOUND_W = 32;

	// request kinds
	localparam logic ACT_RANGE = 1'b0;
	localparam logic ACT_UNIT  = 1'b1;

	// result status codes
	localparam logic STS_OK      = 1'b0;
	localparam logic STS_BAD_ARG = 1'b1;

	// one classified request, handed from front to back
	typedef struct packed {
		logic               action;
		logic [BOUND_W-1:0] bound;
		logic               status;
		logic [63:0]        state;
	} job_t;

	// queue occupancy flags
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage : xrng_pkg

`default_nettype wire

// ===== src/xrng_queue.sv =====
// ----------------------------------------------------------------------------
// xrng_queue
// Small first-in first-out buffer of classified jobs between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module xrng_queue
	import xrng_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire job_t    push_job,
	input  wire logic    pop,
	output job_t         pop_job,
	output q_stat_t      stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign pop_job    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count above depth");

	a_ptrs_meet_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		stat.empty |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers differ while empty");

endmodule : xrng_queue

`default_nettype wire

// ===== src/xrng_front.sv =====
// ----------------------------------------------------------------------------
// xrng_front
// Holds the generator state, takes seed writes and requests, advances the
// state and hands each classified request to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module xrng_front
	import xrng_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [63:0]        seed,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               action,
	input  wire logic [BOUND_W-1:0] bound,
	input  wire q_stat_t            q_stat,
	output logic                    push,
	output job_t                    push_job
);

	logic [63:0] gen_state_q;
	logic [63:0] s1;
	logic [63:0] s2;
	logic [63:0] s3;
	logic        zero_bound;
	logic        take;

	assign s1 = gen_state_q ^ (gen_state_q >> 12);
	assign s2 = s1 ^ (s1 << 25);
	assign s3 = s2 ^ (s2 >> 27);

	// a range draw with no room leaves the state where it is
	assign zero_bound = (action == ACT_RANGE) && (bound == '0);

	assign cfg_ready = 1'b1;
	assign in_ready  = !q_stat.full;
	assign take      = in_valid && in_ready;
	assign push      = take;

	assign push_job.action = action;
	assign push_job.bound  = bound;
	assign push_job.status = zero_bound ? STS_BAD_ARG : STS_OK;
	assign push_job.state  = s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_state_q <= GEN_DEFAULT;
		end else if (cfg_valid && cfg_ready) begin
			gen_state_q <= (seed != '0) ? seed : GEN_DEFAULT;
		end else if (take && !zero_bound) begin
			gen_state_q <= s3;
		end
	end

	a_state_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		gen_state_q != '0)
		else $error("generator state reached zero");

endmodule : xrng_front

`default_nettype wire

// ===== src/xrng_back.sv =====
// ----------------------------------------------------------------------------
// xrng_back
// Pops jobs, forms the xorshift64* product on one shared 32x32 multiplier,
// scales range draws and drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module xrng_back
	import xrng_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire q_stat_t            q_stat,
	input  wire job_t               pop_job,
	output logic                    pop,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    status,
	output logic [VALUE_W-1:0]      value
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LL   = 3'd1;
	localparam logic [2:0] S_HL   = 3'd2;
	localparam logic [2:0] S_LH   = 3'd3;
	localparam logic [2:0] S_SUM  = 3'd4;
	localparam logic [2:0] S_RNG  = 3'd5;
	localparam logic [2:0] S_WAIT = 3'd6;
	localparam logic [2:0] S_FIN  = 3'd7;

	localparam logic [31:0] MULT_LO = GEN_MULT[31:0];
	localparam logic [31:0] MULT_HI = GEN_MULT[63:32];

	logic [2:0]         state_q;
	job_t               job_q;
	logic [31:0]        mul_a;
	logic [31:0]        mul_b;
	logic [63:0]        mul_q;
	logic [63:0]        pll_q;
	logic [31:0]        cross_q;
	logic [31:0]        p_hi_q;
	logic               out_valid_q;
	logic               status_q;
	logic [VALUE_W-1:0] value_q;
	logic               out_free;
	logic [VALUE_W-1:0] result;

	assign pop      = (state_q == S_IDLE) && !q_stat.empty;
	assign out_free = !out_valid_q || out_ready;

	// operand select for the shared multiplier
	always_comb begin
		case (state_q)
			S_LL: begin
				mul_a = job_q.state[31:0];
				mul_b = MULT_LO;
			end
			S_HL: begin
				mul_a = job_q.state[63:32];
				mul_b = MULT_LO;
			end
			S_LH: begin
				mul_a = job_q.state[31:0];
				mul_b = MULT_HI;
			end
			S_RNG: begin
				mul_a = p_hi_q;
				mul_b = job_q.bound;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		if (job_q.status == STS_BAD_ARG) begin
			result = '0;
		end else if (job_q.action == ACT_UNIT) begin
			result = {p_hi_q, pll_q[31:11]};
		end else begin
			result = {{(VALUE_W - 32){1'b0}}, mul_q[63:32]};
		end
	end

	always_ff @(posedge clk) begin
		// product held through the wait and a stalled finish
		if (state_q == S_LL || state_q == S_HL || state_q == S_LH || state_q == S_RNG) begin
			mul_q <= mul_a * mul_b;
		end
		if (pop) begin
			job_q <= pop_job;
		end
		if (state_q == S_HL) begin
			pll_q <= mul_q;
		end
		if (state_q == S_LH) begin
			cross_q <= mul_q[31:0];
		end
		if (state_q == S_SUM) begin
			// upper word of the product modulo 2^64
			p_hi_q <= pll_q[63:32] + cross_q + mul_q[31:0];
		end
		if (state_q == S_FIN && out_free) begin
			status_q <= job_q.status;
			value_q  <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (pop) begin
						state_q <= (pop_job.status == STS_BAD_ARG) ? S_FIN : S_LL;
					end
				end
				S_LL:   state_q <= S_HL;
				S_HL:   state_q <= S_LH;
				S_LH:   state_q <= S_SUM;
				S_SUM:  state_q <= (job_q.action == ACT_UNIT) ? S_FIN : S_RNG;
				S_RNG:  state_q <= S_WAIT;
				S_WAIT: state_q <= S_FIN;
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign value     = value_q;

	a_rng_only_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RNG) |-> (job_q.action == ACT_RANGE && job_q.status == STS_OK))
		else $error("scaling step on a job that needs none");

	a_bad_arg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == STS_BAD_ARG) |-> (value_q == '0))
		else $error("invalid result carries a nonzero value");

endmodule : xrng_back

`default_nettype wire

// ===== src/xorshift64star_range_unit_rng.sv =====
// ----------------------------------------------------------------------------
// xorshift64star_range_unit_rng
// xorshift64* generator with bounded-integer and Q0.53 unit draws.
// ----------------------------------------------------------------------------
// Channels: requests (action, bound) on in_valid/in_ready, results
// (status, value) on out_valid/out_ready, seed writes on cfg_valid/cfg_ready.
// A seed word loads the generator state at once; zero loads the default
// constant. Write the seed only while no request is outstanding.
// The front advances the state in the cycle a request is taken, unless it is
// a zero-bound range draw, and queues the job, so in_ready stays high while the
// queue has room. The back forms the 64-bit product on one 32x32 multiplier
// in three passes, then one more pass scales a range draw by its bound.
// A zero-bound range draw skips the multiplier (status 1, value 0).
// The back takes one job at a time and pops the next only after the result
// of the current job has gone to the output register.
// A stalled receiver holds the output register; the back then waits with one
// finished job and the queue fills before in_ready drops.
// Reset clears the queue and output and loads the default constant.
// ----------------------------------------------------------------------------
`default_nettype none

module xorshift64star_range_unit_rng
	import xrng_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [63:0]        seed,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               action,
	input  wire logic [BOUND_W-1:0] bound,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    status,
	output logic [VALUE_W-1:0]      value
);

	q_stat_t q_stat;
	logic    push;
	job_t    push_job;
	logic    pop;
	job_t    pop_job;

	xrng_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.seed      (seed),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.bound     (bound),
		.q_stat    (q_stat),
		.push      (push),
		.push_job  (push_job)
	);

	xrng_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.pop_job  (pop_job),
		.stat     (q_stat)
	);

	xrng_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.pop_job   (pop_job),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.value     (value)
	);

endmodule : xorshift64star_range_unit_rng

`default_nettype wire
